>>> rtl/midi_track_event_parser_macros.svh
// ---------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Shared property wrappers for the parser RTL.
// ---------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// same-cycle implication
`define MTEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mtep_pkg.sv
// ---------------------------------------------------------------------------
// mtep_pkg
// Types, phase codes, event kinds and byte constants of the track parser.
// ---------------------------------------------------------------------------
package mtep_pkg;

	localparam int TICK_W  = 40;
	localparam int COUNT_W = 32;
	localparam int VLQ_W   = 28;
	localparam int HELD_W  = 24;
	localparam int IDX_W   = 3;
	localparam int PHASE_W = 4;
	localparam int KIND_W  = 3;
	localparam int MODE_W  = 2;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_DELTA     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_STATUS    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_DATA      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SYSEX     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_SKIP      = 4'd4;
	localparam logic [PHASE_W-1:0] PH_META_TYPE = 4'd5;
	localparam logic [PHASE_W-1:0] PH_META_LEN  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_TEMPO     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_DONE      = 4'd8;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CHAN3    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CHAN2    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SYSEX    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TEMPO    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_EOT      = 3'd6;
	localparam logic [KIND_W-1:0] KIND_BAD_RS   = 3'd7;

	// emit modes
	localparam logic [MODE_W-1:0] MODE_SYNTH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NOTES = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALL   = 2'd2;

	// bytes and nibbles
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_EOX     = 8'hF7;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_SONGSEL = 8'hF3;
	localparam logic [7:0] ST_META    = 8'hFF;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	localparam logic [IDX_W-1:0] TEMPO_LAST_IDX = 3'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [7:0]         status_byte;
		logic [7:0]         data_first;
		logic [7:0]         data_second;
		logic [HELD_W-1:0]  tempo_value;
		logic [TICK_W-1:0]  event_tick;
		logic               sysex_last;
		logic               track_has_notes;
		logic [COUNT_W-1:0] note_total;
	} res_t;

endpackage

>>> rtl/midi_track_event_parser.sv
// ---------------------------------------------------------------------------
// midi_track_event_parser: input register, parse logic, then result register.
// Throughput one byte per cycle; a word held in the result register with
// out_ready low stalls the parser, and bytes that report nothing wait too.
// Async active-low reset clears parse state, note count, mode to all (2).
// ---------------------------------------------------------------------------
module midi_track_event_parser
	import mtep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// byte input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               track_start,
	// event output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KIND_W-1:0]  event_kind,
	output logic [7:0]         status_byte,
	output logic [7:0]         data_first,
	output logic [7:0]         data_second,
	output logic [HELD_W-1:0]  tempo_value,
	output logic [TICK_W-1:0]  event_tick,
	output logic               sysex_last,
	output logic               track_has_notes,
	output logic [COUNT_W-1:0] note_total,
	// mode register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MODE_W-1:0]  cfg_data
);

	item_t             in_item;
	item_t             item_s1;
	logic              valid_s1;
	logic              out_free;
	logic              advance;
	logic              res_valid;
	res_t              res;
	res_t              res_s2;
	logic [MODE_W-1:0] mode_q;

	// mode register; user writes it only while the parser is idle, block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ALL;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign in_item.data_byte   = data_byte;
	assign in_item.track_start = track_start;

	// A held byte is parsed in the cycle the result register can take its
	// word (empty, or draining this cycle). Bytes that produce no event still
	// wait for that slot, which keeps the parse state and the event order tied.
	assign advance = valid_s1 && out_free;

	mtep_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Parse state advances on the same edge that loads the result register.
	mtep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.emit_mode (mode_q),
		.res_valid (res_valid),
		.res       (res)
	);

	mtep_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_valid (res_valid),
		.load_res   (res),
		.out_ready  (out_ready),
		.out_free   (out_free),
		.valid_s2   (out_valid),
		.res_s2     (res_s2)
	);

	// event word fields
	assign event_kind      = res_s2.event_kind;
	assign status_byte     = res_s2.status_byte;
	assign data_first      = res_s2.data_first;
	assign data_second     = res_s2.data_second;
	assign tempo_value     = res_s2.tempo_value;
	assign event_tick      = res_s2.event_tick;
	assign sysex_last      = res_s2.sysex_last;
	assign track_has_notes = res_s2.track_has_notes;
	assign note_total      = res_s2.note_total;

endmodule

>>> rtl/mtep_in_stage.sv
// ---------------------------------------------------------------------------
// mtep_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ---------------------------------------------------------------------------
module mtep_in_stage
	import mtep_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/mtep_core.sv
// ---------------------------------------------------------------------------
// mtep_core
// Parse state and one-byte decode: delta time, running status, metas, sysex.
// ---------------------------------------------------------------------------
`include "midi_track_event_parser_macros.svh"

module mtep_core
	import mtep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  item_t             item,
	input  logic [MODE_W-1:0] emit_mode,
	output logic              res_valid,
	output res_t              res
);

	logic [PHASE_W-1:0] phase_q, c_phase, n_phase;
	logic [7:0]         rs_q, c_rs, n_rs;
	logic [VLQ_W-1:0]   delta_q, c_delta, n_delta;
	logic [TICK_W-1:0]  tick_q, c_tick, n_tick;
	logic [VLQ_W-1:0]   skip_q, c_skip, n_skip;
	logic [HELD_W-1:0]  held_q, c_held, n_held;
	logic [IDX_W-1:0]   idx_q, c_idx, n_idx;
	logic [COUNT_W-1:0] cnt_q, n_cnt;
	logic               seen_q, c_seen, n_seen;

	logic [7:0]         b;
	logic [VLQ_W-1:0]   vlq;
	logic [TICK_W:0]    tick_sum;
	logic               take;
	logic [IDX_W-1:0]   t_idx;
	logic [7:0]         t_held;
	logic               one_byte;
	logic [3:0]         hi;
	logic               ev;
	logic               pass;
	logic [KIND_W-1:0]  ev_kind;
	logic [7:0]         ev_st, ev_d1, ev_d2;
	logic [HELD_W-1:0]  ev_tempo;
	logic               ev_last;

	// track_start clears the per-track state ahead of the byte
	always_comb begin
		b = item.data_byte;
		if (item.track_start) begin
			c_phase = PH_DELTA;
			c_rs    = '0;
			c_delta = '0;
			c_tick  = '0;
			c_skip  = '0;
			c_held  = '0;
			c_idx   = '0;
			c_seen  = 1'b0;
		end else begin
			c_phase = phase_q;
			c_rs    = rs_q;
			c_delta = delta_q;
			c_tick  = tick_q;
			c_skip  = skip_q;
			c_held  = held_q;
			c_idx   = idx_q;
			c_seen  = seen_q;
		end
	end

	always_comb begin
		n_phase  = c_phase;
		n_rs     = c_rs;
		n_delta  = c_delta;
		n_tick   = c_tick;
		n_skip   = c_skip;
		n_held   = c_held;
		n_idx    = c_idx;
		n_cnt    = cnt_q;
		n_seen   = c_seen;
		ev       = 1'b0;
		ev_kind  = KIND_NOTE_ON;
		ev_st    = '0;
		ev_d1    = '0;
		ev_d2    = '0;
		ev_tempo = '0;
		ev_last  = 1'b0;
		take     = 1'b0;
		t_idx    = c_idx;
		t_held   = c_held[7:0];
		vlq      = '0;
		tick_sum = '0;
		hi       = c_rs[7:4];
		one_byte = (hi == NIB_PROGRAM) || (hi == NIB_PRESSURE);

		unique case (c_phase)
			PH_DELTA: begin
				vlq      = {c_delta[VLQ_W-8:0], b[6:0]};
				tick_sum = {1'b0, c_tick} + (TICK_W+1)'(vlq);
				if (!b[7]) begin
					n_tick  = tick_sum[TICK_W] ? '1 : tick_sum[TICK_W-1:0];
					n_delta = '0;
					n_phase = PH_STATUS;
				end else begin
					n_delta = vlq;
				end
			end
			PH_STATUS: begin
				n_held = '0;
				n_idx  = '0;
				if (!b[7]) begin
					if (c_rs == 8'h00) begin
						n_phase = PH_DONE;
						ev      = 1'b1;
						ev_kind = KIND_BAD_RS;
						ev_d1   = b;
					end else begin
						n_phase = PH_DATA;
						take    = 1'b1;
						t_idx   = '0;
						t_held  = '0;
					end
				end else if (b[7:4] != NIB_SYSTEM) begin
					n_rs    = b;
					n_phase = PH_DATA;
				end else begin
					n_rs = '0;
					if (b == ST_SYSEX) begin
						n_phase = PH_SYSEX;
						ev      = 1'b1;
						ev_kind = KIND_SYSEX;
						ev_st   = ST_SYSEX;
						ev_d1   = ST_SYSEX;
					end else if (b == ST_SONGPOS) begin
						n_skip  = VLQ_W'(2);
						n_phase = PH_SKIP;
					end else if (b == ST_SONGSEL) begin
						n_skip  = VLQ_W'(1);
						n_phase = PH_SKIP;
					end else if (b == ST_META) begin
						n_phase = PH_META_TYPE;
					end else begin
						n_phase = PH_DELTA;
					end
				end
			end
			PH_DATA: begin
				take = 1'b1;
			end
			PH_SYSEX: begin
				ev      = 1'b1;
				ev_kind = KIND_SYSEX;
				ev_st   = ST_SYSEX;
				ev_d1   = b;
				if (b == ST_EOX) begin
					ev_last = 1'b1;
					n_phase = PH_DELTA;
				end
			end
			PH_SKIP: begin
				if (c_skip <= VLQ_W'(1)) begin
					n_skip  = '0;
					n_phase = PH_DELTA;
				end else begin
					n_skip = c_skip - VLQ_W'(1);
				end
			end
			PH_META_TYPE: begin
				if (b == META_TEMPO) begin
					n_idx   = '0;
					n_held  = '0;
					n_phase = PH_TEMPO;
				end else if (b == META_EOT) begin
					n_phase = PH_DONE;
					ev      = 1'b1;
					ev_kind = KIND_EOT;
					ev_st   = ST_META;
					ev_d1   = META_EOT;
				end else begin
					n_skip  = '0;
					n_phase = PH_META_LEN;
				end
			end
			PH_META_LEN: begin
				vlq    = {c_skip[VLQ_W-8:0], b[6:0]};
				n_skip = vlq;
				if (!b[7]) begin
					n_phase = (vlq != '0) ? PH_SKIP : PH_DELTA;
				end
			end
			PH_TEMPO: begin
				if (c_idx == '0) begin
					n_skip = VLQ_W'(b);
					n_idx  = IDX_W'(1);
				end else begin
					n_held = {c_held[HELD_W-9:0], b};
					n_idx  = c_idx + IDX_W'(1);
					if (c_idx >= TEMPO_LAST_IDX) begin
						ev       = 1'b1;
						ev_kind  = KIND_TEMPO;
						ev_st    = ST_META;
						ev_d1    = c_skip[7:0];
						ev_d2    = META_TEMPO;
						ev_tempo = {c_held[HELD_W-9:0], b};
						n_skip   = '0;
						n_idx    = '0;
						n_held   = '0;
						n_phase  = PH_DELTA;
					end
				end
			end
			default: begin
			end
		endcase

		// channel data byte, shared by the status and data phases
		if (take) begin
			if (t_idx == '0 && !one_byte) begin
				n_held = HELD_W'(b);
				n_idx  = IDX_W'(1);
			end else begin
				n_phase = PH_DELTA;
				n_idx   = '0;
				n_held  = '0;
				ev      = 1'b1;
				ev_st   = c_rs;
				ev_d1   = one_byte ? b : t_held;
				ev_d2   = one_byte ? 8'h00 : b;
				if (hi == NIB_NOTE_ON) begin
					n_cnt   = (&cnt_q) ? cnt_q : cnt_q + COUNT_W'(1);
					n_seen  = 1'b1;
					ev_kind = KIND_NOTE_ON;
				end else if (hi == NIB_NOTE_OFF) begin
					ev_kind = KIND_NOTE_OFF;
				end else if (one_byte) begin
					ev_kind = KIND_CHAN2;
				end else begin
					ev_kind = KIND_CHAN3;
				end
			end
		end
	end

	// mode filter; the unused mode code reports everything
	always_comb begin
		case (emit_mode)
			MODE_SYNTH: pass = (ev_kind >= KIND_CHAN3) && (ev_kind <= KIND_TEMPO);
			MODE_NOTES: pass = (ev_kind <= KIND_NOTE_OFF);
			default:    pass = 1'b1;
		endcase
	end

	assign res_valid           = ev && pass;
	assign res.event_kind      = ev_kind;
	assign res.status_byte     = ev_st;
	assign res.data_first      = ev_d1;
	assign res.data_second     = ev_d2;
	assign res.tempo_value     = ev_tempo;
	assign res.event_tick      = n_tick;
	assign res.sysex_last      = ev_last;
	assign res.track_has_notes = n_seen;
	assign res.note_total      = n_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			rs_q    <= '0;
			delta_q <= '0;
			tick_q  <= '0;
			skip_q  <= '0;
			held_q  <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			rs_q    <= n_rs;
			delta_q <= n_delta;
			tick_q  <= n_tick;
			skip_q  <= n_skip;
			held_q  <= n_held;
			idx_q   <= n_idx;
			cnt_q   <= n_cnt;
			seen_q  <= n_seen;
		end
	end

	`MTEP_ASSERT_NEXT(a_delta_end, clk, arst_n,
		step && (phase_q == PH_DELTA || item.track_start) && !item.data_byte[7],
		phase_q == PH_STATUS, "delta time end did not move to status")
	`MTEP_ASSERT_NEXT(a_done_sticks, clk, arst_n,
		step && phase_q == PH_DONE && !item.track_start,
		phase_q == PH_DONE, "parser left done without track start")
	`MTEP_ASSERT_NEXT(a_cnt_mono, clk, arst_n, 1'b1,
		cnt_q >= $past(cnt_q), "note counter went backwards")
	`MTEP_ASSERT_NEXT(a_note_seen, clk, arst_n,
		step && ev && ev_kind == KIND_NOTE_ON,
		seen_q, "note on without track note flag")

endmodule

>>> rtl/mtep_out_stage.sv
// ---------------------------------------------------------------------------
// mtep_out_stage
// Result register: holds one event word until the sink takes it.
// ---------------------------------------------------------------------------
module mtep_out_stage
	import mtep_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic load_valid,
	input  res_t load_res,
	input  logic out_ready,
	output logic out_free,
	output logic valid_s2,
	output res_t res_s2
);

	assign out_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= load_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_s2 <= load_res;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: MIDI track event parser testbench
// Streams track bytes through the parser under random sender bursts and
// receiver stalls. A local track decoder predicts every reported event, and
// each event taken from the output channel is checked against the oldest
// prediction. The emit mode is rewritten between phases while the block idles.
// ---------------------------------------------------------------------------
module tb;
	import mtep_pkg::*;

	// cycles to let a byte that reports nothing clear the input and result registers
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES  = 450;
	localparam logic [TICK_W-1:0] TICK_CEIL = '1;
	// spare encoding of the mode field, decodes as report-all
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// byte channel
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte = '0;
	logic               track_start = 1'b0;
	// event channel
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [KIND_W-1:0]  event_kind;
	logic [7:0]         status_byte;
	logic [7:0]         data_first;
	logic [7:0]         data_second;
	logic [HELD_W-1:0]  tempo_value;
	logic [TICK_W-1:0]  event_tick;
	logic               sysex_last;
	logic               track_has_notes;
	logic [COUNT_W-1:0] note_total;
	// mode register channel
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [MODE_W-1:0]  cfg_data = '0;

	midi_track_event_parser DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.track_start     (track_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.status_byte     (status_byte),
		.data_first      (data_first),
		.data_second     (data_second),
		.tempo_value     (tempo_value),
		.event_tick      (event_tick),
		.sysex_last      (sysex_last),
		.track_has_notes (track_has_notes),
		.note_total      (note_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Track decoder: mirrors the parser state, one call per accepted word.
	// -----------------------------------------------------------------------
	logic [PHASE_W-1:0] trk_phase  = PH_DELTA;
	logic [7:0]         run_status = '0;
	logic [VLQ_W-1:0]   vlq_acc    = '0;
	logic [TICK_W-1:0]  abs_tick   = '0;
	logic [VLQ_W-1:0]   skip_cnt   = '0;
	logic [HELD_W-1:0]  held       = '0;
	logic [IDX_W-1:0]   hold_idx   = '0;
	logic [COUNT_W-1:0] note_cnt   = '0;
	logic               trk_notes  = 1'b0;
	logic [MODE_W-1:0]  mode_reg   = MODE_ALL;

	// returns 1 when the byte produces an event the current mode lets out
	function automatic bit decode_track_byte(input logic [7:0] b, input logic ts,
			output res_t ev);
		bit                hit;
		bit                chan_data;
		bit                one_data;
		bit                pass;
		bit                last;
		logic [KIND_W-1:0] k;
		logic [7:0]        st;
		logic [7:0]        d1;
		logic [7:0]        d2;
		logic [HELD_W-1:0] tempo;
		hit = 1'b0;
		chan_data = 1'b0;
		last = 1'b0;
		k = KIND_NOTE_ON;
		st = '0;
		d1 = '0;
		d2 = '0;
		tempo = '0;
		ev = '0;
		if (ts) begin
			trk_phase = PH_DELTA;
			run_status = '0;
			vlq_acc = '0;
			abs_tick = '0;
			skip_cnt = '0;
			held = '0;
			hold_idx = '0;
			trk_notes = 1'b0;
		end
		case (trk_phase)
			PH_DELTA: begin
				// 7 bits per byte, anything above bit 27 falls off
				vlq_acc = {vlq_acc[VLQ_W-8:0], b[6:0]};
				if (!b[7]) begin
					if (abs_tick > TICK_CEIL - TICK_W'(vlq_acc))
						abs_tick = TICK_CEIL;
					else
						abs_tick = abs_tick + TICK_W'(vlq_acc);
					vlq_acc = '0;
					trk_phase = PH_STATUS;
				end
			end
			PH_STATUS: begin
				held = '0;
				hold_idx = '0;
				if (!b[7]) begin
					if (run_status == '0) begin
						// data with nothing to run on: report and go dead
						trk_phase = PH_DONE;
						hit = 1'b1;
						k = KIND_BAD_RS;
						d1 = b;
					end else begin
						trk_phase = PH_DATA;
						chan_data = 1'b1;
					end
				end else if (b[7:4] != NIB_SYSTEM) begin
					run_status = b;
					trk_phase = PH_DATA;
				end else begin
					// any system byte drops running status
					run_status = '0;
					case (b)
						ST_SYSEX: begin
							trk_phase = PH_SYSEX;
							hit = 1'b1;
							k = KIND_SYSEX;
							st = ST_SYSEX;
							d1 = ST_SYSEX;
						end
						ST_SONGPOS: begin
							skip_cnt = VLQ_W'(2);
							trk_phase = PH_SKIP;
						end
						ST_SONGSEL: begin
							skip_cnt = VLQ_W'(1);
							trk_phase = PH_SKIP;
						end
						ST_META: trk_phase = PH_META_TYPE;
						default: trk_phase = PH_DELTA;
					endcase
				end
			end
			PH_DATA: chan_data = 1'b1;
			PH_SYSEX: begin
				hit = 1'b1;
				k = KIND_SYSEX;
				st = ST_SYSEX;
				d1 = b;
				if (b == ST_EOX) begin
					last = 1'b1;
					trk_phase = PH_DELTA;
				end
			end
			PH_SKIP: begin
				if (skip_cnt <= VLQ_W'(1)) begin
					skip_cnt = '0;
					trk_phase = PH_DELTA;
				end else begin
					skip_cnt = skip_cnt - VLQ_W'(1);
				end
			end
			PH_META_TYPE: begin
				if (b == META_TEMPO) begin
					hold_idx = '0;
					held = '0;
					trk_phase = PH_TEMPO;
				end else if (b == META_EOT) begin
					// length byte is left unread, the track is dead from here
					trk_phase = PH_DONE;
					hit = 1'b1;
					k = KIND_EOT;
					st = ST_META;
					d1 = META_EOT;
				end else begin
					skip_cnt = '0;
					trk_phase = PH_META_LEN;
				end
			end
			PH_META_LEN: begin
				skip_cnt = {skip_cnt[VLQ_W-8:0], b[6:0]};
				if (!b[7])
					trk_phase = (skip_cnt != '0) ? PH_SKIP : PH_DELTA;
			end
			PH_TEMPO: begin
				// length byte kept for the report, then three tempo bytes
				if (hold_idx == '0) begin
					skip_cnt = VLQ_W'(b);
					hold_idx = IDX_W'(1);
				end else begin
					held = {held[HELD_W-9:0], b};
					hold_idx = hold_idx + IDX_W'(1);
					if (hold_idx > TEMPO_LAST_IDX) begin
						hit = 1'b1;
						k = KIND_TEMPO;
						st = ST_META;
						d1 = skip_cnt[7:0];
						d2 = META_TEMPO;
						tempo = held;
						skip_cnt = '0;
						hold_idx = '0;
						held = '0;
						trk_phase = PH_DELTA;
					end
				end
			end
			default: ;
		endcase
		if (chan_data) begin
			one_data = (run_status[7:4] == NIB_PROGRAM) || (run_status[7:4] == NIB_PRESSURE);
			if (hold_idx == '0 && !one_data) begin
				held = HELD_W'(b);
				hold_idx = IDX_W'(1);
			end else begin
				d1 = one_data ? b : held[7:0];
				d2 = one_data ? 8'h00 : b;
				st = run_status;
				trk_phase = PH_DELTA;
				hold_idx = '0;
				held = '0;
				hit = 1'b1;
				if (run_status[7:4] == NIB_NOTE_ON) begin
					if (note_cnt != '1)
						note_cnt = note_cnt + COUNT_W'(1);
					trk_notes = 1'b1;
					k = KIND_NOTE_ON;
				end else if (run_status[7:4] == NIB_NOTE_OFF) begin
					k = KIND_NOTE_OFF;
				end else if (one_data) begin
					k = KIND_CHAN2;
				end else begin
					k = KIND_CHAN3;
				end
			end
		end
		if (mode_reg == MODE_SYNTH)
			pass = (k >= KIND_CHAN3) && (k <= KIND_TEMPO);
		else if (mode_reg == MODE_NOTES)
			pass = (k <= KIND_NOTE_OFF);
		else
			pass = 1'b1;
		if (hit && pass) begin
			ev.event_kind = k;
			ev.status_byte = st;
			ev.data_first = d1;
			ev.data_second = d2;
			ev.tempo_value = tempo;
			ev.event_tick = abs_tick;
			ev.sysex_last = last;
			ev.track_has_notes = trk_notes;
			ev.note_total = note_cnt;
		end
		return hit && pass;
	endfunction

	function automatic string fmt_event(input res_t e);
		return $sformatf("kind %0d st %h d %h %h tempo %h tick %h last %b notes %b total %0d",
			e.event_kind, e.status_byte, e.data_first, e.data_second, e.tempo_value,
			e.event_tick, e.sysex_last, e.track_has_notes, e.note_total);
	endfunction

	// -----------------------------------------------------------------------
	// Byte driver: bursts of random length, random gaps, changes on negedge.
	// -----------------------------------------------------------------------
	item_t byte_q[$];
	res_t  event_q[$];
	int    bytes_queued = 0;
	bit    track_fresh = 1'b0;
	logic  in_took = 1'b0;
	int    burst_left = 0;
	int    gap_left = 0;

	always @(negedge clk) begin : drive_bytes
		item_t cur;
		// only move on once the word in flight has been taken
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left != 0 || byte_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				cur = byte_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= cur.data_byte;
				track_start <= cur.track_start;
				// gap of zero gives back-to-back bursts
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: a new stall style for each random span, style 0 never stalls
	int          stall_span = 0;
	int          stall_style = 0;
	logic [31:0] stall_bits = '0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_bits = $urandom;
			stall_span = $urandom_range(16, 64);
		end
		stall_span = stall_span - 1;
		stall_bits = {stall_bits[30:0], stall_bits[31]};
		case (stall_style)
			0: out_ready <= 1'b1;
			1: out_ready <= stall_bits[0];
			2: out_ready <= stall_bits[0] | stall_bits[1];
			default: out_ready <= (stall_span[1:0] == 2'd0);
		endcase
	end

	// -----------------------------------------------------------------------
	// Monitor: everything sampled on the rising edge.
	// -----------------------------------------------------------------------
	int mismatches = 0;

	always @(posedge clk) begin : watch_channels
		res_t got;
		res_t want;
		res_t ev;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (cfg_valid && cfg_ready)
				mode_reg = cfg_data;
			if (out_valid && out_ready) begin
				got = {event_kind, status_byte, data_first, data_second, tempo_value,
					event_tick, sysex_last, track_has_notes, note_total};
				if (event_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: event with none pending: %s", $realtime, fmt_event(got));
				end else begin
					want = event_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: event mismatch", $realtime);
							$display("  want %s", fmt_event(want));
							$display("  got  %s", fmt_event(got));
						end
					end
				end
			end
			// predict after the check so a same-edge event cannot match itself
			if (in_valid && in_ready && decode_track_byte(data_byte, track_start, ev))
				event_q.push_back(ev);
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b);
		item_t it;
		it.data_byte = b;
		it.track_start = track_fresh;
		track_fresh = 1'b0;
		byte_q.push_back(it);
		bytes_queued++;
	endtask

	// variable-length number, shortest encoding
	task automatic add_vlq(input logic [VLQ_W-1:0] v);
		int n;
		n = (v >= (1 << 21)) ? 4 : (v >= (1 << 14)) ? 3 : (v >= (1 << 7)) ? 2 : 1;
		for (int i = n - 1; i >= 0; i--)
			add_byte({(i != 0), v[7*i +: 7]});
	endtask

	// mostly clean 7-bit data, now and then a byte with the top bit set
	function automatic logic [7:0] data_val();
		logic [7:0] v;
		v = 8'($urandom);
		if ($urandom_range(0, 15) != 0)
			v[7] = 1'b0;
		return v;
	endfunction

	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || event_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		@(negedge clk);
		cfg_data <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed events with random content, plus broken pieces
	task automatic random_traffic(input int n_bytes);
		int               stop;
		int               pick;
		int               len;
		logic [7:0]       st;
		logic [7:0]       last_st;
		logic [VLQ_W-1:0] dt;
		stop = bytes_queued + n_bytes;
		last_st = '0;
		while (bytes_queued < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// raw noise, track starts sprinkled in
				repeat ($urandom_range(1, 8)) begin
					track_fresh = ($urandom_range(0, 7) == 0);
					add_byte(8'($urandom));
				end
				last_st = '0;
			end else if (pick < 12) begin
				track_fresh = 1'b1;
				last_st = '0;
				if ($urandom_range(0, 4) == 0) begin
					// data where the first status belongs, rest of track is dead
					add_byte(8'h00);
					add_byte(8'($urandom_range(0, 127)));
					add_byte(8'($urandom));
					track_fresh = 1'b1;
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					dt = VLQ_W'($urandom_range(0, 127));
				else if (pick < 90)
					dt = VLQ_W'($urandom_range(0, 16383));
				else if (pick < 98)
					dt = VLQ_W'($urandom_range(0, (1 << 21) - 1));
				else
					dt = VLQ_W'($urandom_range(0, (1 << 28) - 1));
				// overlong delta now and then, its top bits get dropped
				if ($urandom_range(0, 31) == 0)
					add_byte(8'h80 | 8'($urandom));
				add_vlq(dt);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					st[7:4] = 4'($urandom_range(NIB_NOTE_OFF, NIB_SYSTEM - 1));
					st[3:0] = 4'($urandom);
					if (pick < 25)
						st[7:4] = NIB_NOTE_ON;
					else if (pick < 33)
						st[7:4] = NIB_NOTE_OFF;
					if (last_st != '0 && $urandom_range(0, 1) == 1)
						st = last_st;
					else
						add_byte(st);
					last_st = st;
					add_byte(data_val());
					if (st[7:4] != NIB_PROGRAM && st[7:4] != NIB_PRESSURE)
						add_byte(data_val());
				end else begin
					last_st = '0;
					if (pick < 63) begin
						add_byte(ST_SYSEX);
						repeat ($urandom_range(0, 6)) add_byte(data_val());
						add_byte(ST_EOX);
					end else if (pick < 70) begin
						add_byte(ST_META);
						add_byte(META_TEMPO);
						// length byte is not trusted by the block
						add_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h03);
						repeat (3) add_byte(8'($urandom));
					end else if (pick < 78) begin
						add_byte(ST_META);
						st = 8'($urandom);
						if (st == META_TEMPO || st == META_EOT)
							st = 8'h01;
						add_byte(st);
						len = $urandom_range(0, 6);
						if ($urandom_range(0, 3) == 0)
							add_byte(8'h80);
						add_vlq(VLQ_W'(len));
						repeat (len) add_byte(8'($urandom));
					end else if (pick < 82) begin
						add_byte(ST_SONGPOS);
						add_byte(data_val());
						add_byte(data_val());
					end else if (pick < 86) begin
						add_byte(ST_SONGSEL);
						add_byte(data_val());
					end else if (pick < 94) begin
						// lone system byte, back to the delta time
						st = 8'($urandom_range(8'hF4, 8'hFE));
						case ($urandom_range(0, 3))
							0: st = 8'hF1;
							1: st = ST_EOX;
							default: ;
						endcase
						add_byte(st);
					end else begin
						add_byte(ST_META);
						add_byte(META_EOT);
						add_byte(8'h00);
						track_fresh = 1'b1;
					end
				end
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Test sequence
	// -----------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed track in the reset mode (report all)
		track_fresh = 1'b1;
		add_byte(8'h00); add_byte(8'h90); add_byte(8'h3C); add_byte(8'h7F);
		// two-byte delta, running status note-on with velocity 0
		add_byte(8'h81); add_byte(8'h00); add_byte(8'h3C); add_byte(8'h00);
		add_byte(8'h00); add_byte(8'h80); add_byte(8'h3C); add_byte(8'h40);
		// top-bit bytes inside channel messages count as data
		add_byte(8'h00); add_byte(8'hB0); add_byte(8'h07); add_byte(8'hFF);
		add_byte(8'h00); add_byte(8'hC5); add_byte(8'h80);
		add_byte(8'h00); add_byte(ST_SYSEX); add_byte(8'h81); add_byte(ST_EOX);
		add_byte(8'h00); add_byte(ST_META); add_byte(META_TEMPO);
		add_byte(8'h03); add_byte(8'h07); add_byte(8'hA1); add_byte(8'h20);
		add_byte(8'h00); add_byte(ST_SONGPOS); add_byte(8'h01); add_byte(8'h02);
		add_byte(8'h00); add_byte(ST_SONGSEL); add_byte(8'h05);
		add_byte(8'h00); add_byte(8'hF1);
		add_byte(8'h00); add_byte(ST_META); add_byte(8'h01);
		add_byte(8'h02); add_byte(8'h41); add_byte(8'h42);
		// running status was cleared by the system bytes above
		add_byte(8'h00); add_byte(8'h40); add_byte(8'h55);
		track_fresh = 1'b1;
		add_byte(8'h00); add_byte(ST_META); add_byte(META_EOT);
		add_byte(8'h00); add_byte(8'h90);
		// five-byte delta, high bits lost
		track_fresh = 1'b1;
		add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
		add_byte(8'h7F); add_byte(8'hD0); add_byte(8'h10);
		wait_idle();

		write_mode(MODE_SYNTH);
		random_traffic(PHASE_BYTES);
		wait_idle();

		write_mode(MODE_NOTES);
		random_traffic(PHASE_BYTES);
		wait_idle();

		write_mode(MODE_SPARE);
		random_traffic(PHASE_BYTES);
		wait_idle();

		write_mode(MODE_ALL);
		random_traffic(PHASE_BYTES);
		wait_idle();

		if (mismatches == 0 && event_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/mtep_pkg.sv
rtl/mtep_in_stage.sv
rtl/mtep_core.sv
rtl/mtep_out_stage.sv
rtl/midi_track_event_parser.sv
tb/sv/tb.sv
